### design/aes_cfbd_pkg.sv
// Shared types, constants and AES helper functions for the CFB-128 decryptor.
`timescale 1ns / 1ps
package aes_cfbd_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned QueueDepth = 2;

  typedef logic [8*BlockBytes-1:0] block_t;
  typedef logic [4:0]              count_t;
  typedef logic [3:0]              round_t;
  typedef logic [1:0]              qcount_t;

  localparam round_t  LastRound = 4'd10;
  localparam qcount_t QueueFull = qcount_t'(QueueDepth);

  typedef enum logic [1:0] {
    RegKeyHigh = 2'd0,
    RegKeyLow  = 2'd1,
    RegIvHigh  = 2'd2,
    RegIvLow   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CoreIdle,
    CoreRound
  } core_state_e;

  // one queued job: feedback already resolved against message_start
  typedef struct packed {
    block_t fb;
    block_t ct;
    count_t nbytes;
    logic   last;
  } item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input round_t r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // next round key from the previous one
  function automatic block_t key_step(input block_t w, input round_t r);
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    t  = {SBOX[w[23:16]] ^ rcon(r), SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    n0 = w[127:96] ^ t;
    n1 = w[95:64] ^ n0;
    n2 = w[63:32] ^ n1;
    n3 = w[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // SubBytes, ShiftRows, MixColumns (skipped in the final round), AddRoundKey
  function automatic block_t aes_round(input block_t s, input block_t k, input logic fin);
    logic [7:0] b [BlockBytes];
    logic [7:0] t [BlockBytes];
    logic [7:0] a0, a1, a2, a3, x;
    block_t     o;
    for (int i = 0; i < BlockBytes; i++) begin
      b[i] = SBOX[s[8*BlockBytes-1-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i+4*c] = b[i+4*((c+i)%4)];
      end
    end
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        x  = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < BlockBytes; i++) begin
      o[8*BlockBytes-1-8*i -: 8] = t[i];
    end
    return o ^ k;
  endfunction

endpackage

### design/aes_cfbd_regs.sv
// Configuration registers, iterative key expansion and round key store.
`timescale 1ns / 1ps
module aes_cfbd_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  input  aes_cfbd_pkg::round_t  rk_idx_i,
  output aes_cfbd_pkg::block_t  rk_o,
  output aes_cfbd_pkg::block_t  iv_o,
  output logic                  busy_o
);
  import aes_cfbd_pkg::*;

  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  block_t      rk_q [LastRound+1];
  block_t      kexp_q;
  round_t      cnt_q;
  logic        busy_q;
  logic        wr, key_wr;
  reg_idx_e    idx;
  block_t      new_key, step;

  assign idx     = reg_idx_e'(paddr[4:3]);
  assign wr      = psel & penable & pwrite;
  assign key_wr  = wr & ((idx == RegKeyHigh) || (idx == RegKeyLow));
  assign new_key = {(idx == RegKeyHigh) ? pwdata : key_hi_q,
                    (idx == RegKeyLow)  ? pwdata : key_lo_q};
  assign step    = key_step(kexp_q, cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q  <= '0;
      iv_lo_q  <= '0;
      busy_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        case (idx)
          RegKeyHigh: key_hi_q <= pwdata;
          RegKeyLow:  key_lo_q <= pwdata;
          RegIvHigh:  iv_hi_q  <= pwdata;
          RegIvLow:   iv_lo_q  <= pwdata;
          default:    ;
        endcase
      end
      if (key_wr) begin
        busy_q <= 1'b1;
        cnt_q  <= round_t'(1);
      end else if (busy_q) begin
        cnt_q <= cnt_q + round_t'(1);
        if (cnt_q == LastRound) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_wr) begin
      kexp_q   <= new_key;
      rk_q[0]  <= new_key;
    end else if (busy_q) begin
      kexp_q      <= step;
      rk_q[cnt_q] <= step;
    end
  end

  always_comb begin
    case (idx)
      RegKeyHigh: prdata = key_hi_q;
      RegKeyLow:  prdata = key_lo_q;
      RegIvHigh:  prdata = iv_hi_q;
      RegIvLow:   prdata = iv_lo_q;
      default:    prdata = '0;
    endcase
  end

  assign rk_o   = rk_q[rk_idx_i];
  assign iv_o   = {iv_hi_q, iv_lo_q};
  assign busy_o = busy_q;

endmodule

### design/aes_cfbd_front.sv
// Front end: accepts ciphertext, resolves the feedback block, queues jobs.
`timescale 1ns / 1ps
module aes_cfbd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [63:0]           cipher_high_i,
  input  logic [63:0]           cipher_low_i,
  input  aes_cfbd_pkg::count_t  valid_bytes_i,
  input  logic                  message_start_i,
  input  logic                  message_end_i,
  input  aes_cfbd_pkg::block_t  iv_i,
  input  logic                  hold_i,
  output logic                  q_valid_o,
  output aes_cfbd_pkg::item_t   q_item_o,
  input  logic                  q_take_i
);
  import aes_cfbd_pkg::*;

  item_t   mem_q [QueueDepth];
  logic    wr_ptr_q, rd_ptr_q;
  qcount_t cnt_q;
  block_t  fb_q;
  logic    accept;
  item_t   in_item;

  assign full   = hold_i | (cnt_q == QueueFull);
  assign accept = push & ~full;

  assign in_item.fb     = message_start_i ? iv_i : fb_q;
  assign in_item.ct     = {cipher_high_i, cipher_low_i};
  assign in_item.nbytes = valid_bytes_i;
  assign in_item.last   = message_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q     <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        fb_q     <= in_item.ct;
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_take_i) rd_ptr_q <= ~rd_ptr_q;
      if (accept && !q_take_i) begin
        cnt_q <= cnt_q + qcount_t'(1);
      end else if (!accept && q_take_i) begin
        cnt_q <= cnt_q - qcount_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) mem_q[wr_ptr_q] <= in_item;
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];

endmodule

### design/aes_cfbd_core.sv
// Back end: iterative AES-128 encryption of the feedback and plaintext output register.
`timescale 1ns / 1ps
module aes_cfbd_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  aes_cfbd_pkg::item_t   q_item_i,
  output logic                  q_take_o,
  output aes_cfbd_pkg::round_t  rk_idx_o,
  input  aes_cfbd_pkg::block_t  rk_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [63:0]           plain_high_o,
  output logic [63:0]           plain_low_o,
  output aes_cfbd_pkg::count_t  out_bytes_o,
  output logic                  out_last_o
);
  import aes_cfbd_pkg::*;

  core_state_e state_q, state_d;
  round_t      round_q, round_d;
  block_t      st_q;
  block_t      ct_q;
  count_t      n_q;
  logic        last_q;
  logic        out_valid_q;
  block_t      out_q;
  count_t      out_n_q;
  logic        out_last_q;
  logic        done;
  block_t      ks, plain;

  assign rk_idx_o = (state_q == CoreIdle) ? '0 : round_q;
  // one round unit; MixColumns is dropped in the final round
  assign ks       = aes_round(st_q, rk_i, round_q == LastRound);

  always_comb begin
    for (int i = 0; i < BlockBytes; i++) begin
      plain[8*BlockBytes-1-8*i -: 8] = (count_t'(i) < n_q) ?
          (ct_q[8*BlockBytes-1-8*i -: 8] ^ ks[8*BlockBytes-1-8*i -: 8]) : 8'h00;
    end
  end

  always_comb begin
    state_d  = state_q;
    round_d  = round_q;
    q_take_o = 1'b0;
    done     = 1'b0;
    case (state_q)
      CoreIdle: begin
        if (q_valid_i) begin
          q_take_o = 1'b1;
          state_d  = CoreRound;
          round_d  = round_t'(1);
        end
      end
      CoreRound: begin
        if (round_q != LastRound) begin
          round_d = round_q + round_t'(1);
        end else if (!out_valid_q || pop) begin
          done    = 1'b1;
          state_d = CoreIdle;
        end
      end
      default: state_d = CoreIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CoreIdle;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_take_o) begin
      st_q   <= q_item_i.fb ^ rk_i;
      ct_q   <= q_item_i.ct;
      n_q    <= q_item_i.nbytes;
      last_q <= q_item_i.last;
    end else if (state_q == CoreRound && round_q != LastRound) begin
      st_q <= ks;
    end
    if (done) begin
      out_q      <= plain;
      out_n_q    <= n_q;
      out_last_q <= last_q;
    end
  end

  assign empty        = ~out_valid_q;
  assign plain_high_o = out_q[127:64];
  assign plain_low_o  = out_q[63:0];
  assign out_bytes_o  = out_n_q;
  assign out_last_o   = out_last_q;

endmodule

### design/aes128_cfb_decrypt.sv
// AES-128 CFB-128 decryptor top level.
//
// Push ciphertext blocks in, pop plaintext blocks out, both with queue-style
// handshakes. Each block occupies the AES unit for one load step (with the
// initial key add) and then ten rounds on a single shared round unit, the
// last of which writes the output register; the unit takes the next block
// only after that write. A two-entry job queue lets new blocks be taken while
// one is being decrypted, and the output register lets the unit finish the
// next block while a result waits. A write to either key register starts the
// key expansion, during which full stays high. Key and IV are set through
// the APB-style port at byte addresses 0x00, 0x08, 0x10, 0x18.
`timescale 1ns / 1ps
module aes128_cfb_decrypt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  logic [63:0]           cipher_high_i,
  input  logic [63:0]           cipher_low_i,
  input  aes_cfbd_pkg::count_t  valid_bytes_i,
  input  logic                  message_start_i,
  input  logic                  message_end_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [63:0]           plain_high_o,
  output logic [63:0]           plain_low_o,
  output aes_cfbd_pkg::count_t  out_bytes_o,
  output logic                  out_last_o
);
  import aes_cfbd_pkg::*;

  round_t rk_idx;
  block_t rk, iv;
  logic   kbusy;
  logic   q_valid, q_take;
  item_t  q_item;

  assign pready = 1'b1;

  aes_cfbd_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .rk_idx_i (rk_idx),
    .rk_o     (rk),
    .iv_o     (iv),
    .busy_o   (kbusy)
  );

  aes_cfbd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .cipher_high_i   (cipher_high_i),
    .cipher_low_i    (cipher_low_i),
    .valid_bytes_i   (valid_bytes_i),
    .message_start_i (message_start_i),
    .message_end_i   (message_end_i),
    .iv_i            (iv),
    .hold_i          (kbusy),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_take_i        (q_take)
  );

  aes_cfbd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_take_o     (q_take),
    .rk_idx_o     (rk_idx),
    .rk_i         (rk),
    .empty        (empty),
    .pop          (pop),
    .plain_high_o (plain_high_o),
    .plain_low_o  (plain_low_o),
    .out_bytes_o  (out_bytes_o),
    .out_last_o   (out_last_o)
  );

endmodule

### design/aes_cfbd_checker.sv
// Port-level checker for the CFB decryptor, bound to the top level.
`timescale 1ns / 1ps
module aes_cfbd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [4:0]           paddr,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input logic [63:0]          plain_high_o,
  input logic [63:0]          plain_low_o,
  input aes_cfbd_pkg::count_t out_bytes_o
);
  import aes_cfbd_pkg::*;

  reg_idx_e widx;

  assign widx = reg_idx_e'(paddr[4:3]);

  // unused plaintext bytes must be zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_bytes_o <= count_t'(8)) |-> plain_low_o == '0)
    else $error("plain_low not zero for short block");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_bytes_o == '0) |-> plain_high_o == '0)
    else $error("plain_high not zero for empty block");

  // key write blocks input while round keys are rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (widx == RegKeyHigh || widx == RegKeyLow)) |=> full)
    else $error("input not blocked during key expansion");

  // waiting result holds until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(plain_high_o) && $stable(plain_low_o)))
    else $error("result changed before transfer");

endmodule

bind aes128_cfb_decrypt aes_cfbd_checker u_checker (.*);

### tb/sv/aes128_cfb_decrypt_tb.sv
// Self-checking testbench for the AES-128 CFB-128 decryptor, with a built-in AES predictor.
`timescale 1ns / 1ps
module aes128_cfb_decrypt_tb;
  import aes_cfbd_pkg::*;

  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned DrainWait  = 16;
  localparam int unsigned RandBlocks = 540;

  typedef logic [127:0] blk_t;

  typedef struct {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    count_t      nbytes;
    logic        last;
  } plain_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] cipher_high_i = '0, cipher_low_i = '0;
  count_t      valid_bytes_i = 5'd16;
  logic        message_start_i = 1'b0, message_end_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] plain_high_o, plain_low_o;
  count_t      out_bytes_o;
  logic        out_last_o;

  aes128_cfb_decrypt u_dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
  blk_t        fb_reg;
  blk_t        rkeys [11];
  plain_t      plain_q [$];
  int          errors = 0;
  int          stall_max = 0;
  int          gap_max = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [7:0] sb(input logic [7:0] v);
    return SBOX[v];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  task automatic expand_keys();
    logic [7:0]  rc [11];
    logic [31:0] t, w0, w1, w2, w3;
    blk_t        w;
    rc = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
    rkeys[0] = {key_hi, key_lo};
    for (int r = 1; r <= 10; r++) begin
      w  = rkeys[r-1];
      t  = {sb(w[23:16]) ^ rc[r], sb(w[15:8]), sb(w[7:0]), sb(w[31:24])};
      w0 = w[127:96] ^ t;
      w1 = w[95:64] ^ w0;
      w2 = w[63:32] ^ w1;
      w3 = w[31:0] ^ w2;
      rkeys[r] = {w0, w1, w2, w3};
    end
  endtask

  function automatic blk_t encrypt(input blk_t in);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    blk_t       v;
    v = in ^ rkeys[0];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = sb(v[127-8*i -: 8]);
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = s[i+4*((c+i)%4)];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          x  = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ x ^ xt(a0 ^ a1);
          t[4*c+1] = a1 ^ x ^ xt(a1 ^ a2);
          t[4*c+2] = a2 ^ x ^ xt(a2 ^ a3);
          t[4*c+3] = a3 ^ x ^ xt(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) v[127-8*i -: 8] = t[i];
      v = v ^ rkeys[r];
    end
    return v;
  endfunction

  task automatic predict_plain(input blk_t ct, input count_t n, input logic st,
                               input logic en);
    blk_t   ks, pt;
    plain_t p;
    if (st) fb_reg = {iv_hi, iv_lo};
    ks = encrypt(fb_reg);
    for (int i = 0; i < 16; i++)
      pt[127-8*i -: 8] = (i < n) ? (ct[127-8*i -: 8] ^ ks[127-8*i -: 8]) : 8'h00;
    fb_reg = ct;
    p.plain_high = pt[127:64];
    p.plain_low  = pt[63:0];
    p.nbytes     = n;
    p.last       = en;
    plain_q.insert(plain_q.size(), p);
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    errors++;
    $display("%0t mismatch %s: got %h exp %h", $realtime, what, got, exp);
  endtask

  // called at a falling edge with push low
  task automatic cfg_write(input reg_idx_e idx, input logic [63:0] val);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 3'b000}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      RegKeyHigh: begin key_hi = val; expand_keys(); end
      RegKeyLow:  begin key_lo = val; expand_keys(); end
      RegIvHigh:  iv_hi = val;
      RegIvLow:   iv_lo = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [63:0] kh, input logic [63:0] kl,
                         input logic [63:0] ih, input logic [63:0] il);
    cfg_write(RegKeyHigh, kh);
    cfg_write(RegKeyLow, kl);
    cfg_write(RegIvHigh, ih);
    cfg_write(RegIvLow, il);
  endtask

  // called at a falling edge; returns at a falling edge with push still high
  task automatic send_block(input logic [63:0] ch, input logic [63:0] cl,
                            input count_t n, input logic st, input logic en);
    cipher_high_i = ch; cipher_low_i = cl; valid_bytes_i = n;
    message_start_i = st; message_end_i = en; push = 1'b1;
    do @(posedge clk_i); while (full);
    predict_plain({ch, cl}, n, st, en);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    int g;
    g = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (g != 0) begin
      push = 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    push = 1'b0;
    while (plain_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    set_all(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
            64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    gap_max = 0; stall_max = 0;
    send_block(64'h3b3fd92eb72dad20, 64'h333449f8e83cfb4a, 5'd16, 1'b1, 1'b0);
    send_block(64'hc8a64537a0b3a93f, 64'hcde3cdad9f1ce58b, 5'd16, 1'b0, 1'b0);
    send_block('0, '0, 5'd16, 1'b0, 1'b0);
    send_block('1, '1, 5'd16, 1'b0, 1'b1);
    send_block('1, '1, 5'd1, 1'b1, 1'b1);
    send_block('0, '1, 5'd15, 1'b1, 1'b0);
    // short block that is not final
    send_block('1, '0, 5'd7, 1'b0, 1'b0);
    send_block(rnd64(), rnd64(), 5'd8, 1'b0, 1'b1);
    // counts of zero and above sixteen
    send_block(rnd64(), rnd64(), 5'd0, 1'b1, 1'b0);
    send_block(rnd64(), rnd64(), 5'd17, 1'b0, 1'b0);
    send_block('1, '1, 5'd31, 1'b0, 1'b1);
    // continuation without a start after a final block
    send_block(rnd64(), rnd64(), 5'd16, 1'b0, 1'b0);
    send_block(rnd64(), rnd64(), 5'd9, 1'b0, 1'b1);
    drain();
    set_all('0, '0, '0, '0);
    send_block('0, '0, 5'd16, 1'b1, 1'b1);
    send_block('1, '1, 5'd16, 1'b1, 1'b0);
    drain();
    set_all('1, '1, '1, '1);
    send_block('0, '0, 5'd16, 1'b1, 1'b0);
    send_block('1, '1, 5'd16, 1'b0, 1'b1);
    drain();
  endtask

  task automatic random_traffic(input int nblocks);
    int sent, len, burst;
    count_t n;
    logic st, en;
    sent = 0; burst = 0;
    while (sent < nblocks) begin
      if ($urandom_range(0, 9) == 0) begin
        n  = count_t'($urandom_range(0, 31));
        st = $urandom_range(0, 1);
        en = $urandom_range(0, 1);
        send_block(rnd64(), rnd64(), n, st, en);
        sent++;
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          en = (i == len - 1);
          n  = (en && $urandom_range(0, 1)) ? count_t'($urandom_range(1, 15)) : 5'd16;
          send_block(rnd64(), rnd64(), n, i == 0, en);
          sent++;
          if (burst == 0) begin
            burst = $urandom_range(1, 10);
            sender_gap();
          end else begin
            burst--;
          end
        end
      end
    end
  endtask

  task automatic test_config_sweep();
    gap_max = 6; stall_max = 8;
    set_all(rnd64(), rnd64(), '0, '1);
    random_traffic(40);
    drain();
    set_all('0, '1, rnd64(), '0);
    random_traffic(40);
    drain();
    cfg_write(RegKeyLow, rnd64());
    cfg_write(RegIvHigh, '1);
    random_traffic(40);
    drain();
  endtask

  task automatic test_random();
    set_all(rnd64(), rnd64(), rnd64(), rnd64());
    gap_max = 0; stall_max = 0;
    random_traffic(RandBlocks / 4);
    // hold off until every result has come
    drain();
    gap_max = 15; stall_max = 3;
    random_traffic(RandBlocks / 4);
    gap_max = 2; stall_max = 25;
    random_traffic(RandBlocks / 4);
    drain();
    set_all(rnd64(), rnd64(), rnd64(), rnd64());
    gap_max = 10; stall_max = 10;
    random_traffic(RandBlocks / 4);
    drain();
  endtask

  // receiver stall pattern
  initial begin
    int run, stall;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 12);
      repeat (run) begin
        @(negedge clk_i);
        pop = 1'b1;
      end
      stall = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
      repeat (stall) begin
        @(negedge clk_i);
        pop = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    plain_t e;
    if (rst_ni && pop && !empty) begin
      if (plain_q.size() == 0) begin
        report("unexpected result", plain_high_o, '0);
      end else begin
        e = plain_q.pop_front();
        if (plain_high_o !== e.plain_high) report("plain_high", plain_high_o, e.plain_high);
        if (plain_low_o !== e.plain_low) report("plain_low", plain_low_o, e.plain_low);
        if (out_bytes_o !== e.nbytes) report("out_bytes", 64'(out_bytes_o), 64'(e.nbytes));
        if (out_last_o !== e.last) report("out_last", 64'(out_last_o), 64'(e.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0; fb_reg = '0;
    for (int r = 0; r < 11; r++) rkeys[r] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_sweep();
    test_random();
    drain();
    if (errors == 0 && plain_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
design/aes_cfbd_pkg.sv
design/aes_cfbd_regs.sv
design/aes_cfbd_front.sv
design/aes_cfbd_core.sv
design/aes128_cfb_decrypt.sv
design/aes_cfbd_checker.sv
tb/sv/aes128_cfb_decrypt_tb.sv
